// File: sv/bhc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Barcode classifier package
// Shared constants, codes and the word type that moves along the cell chain.
// ----------------------------------------------------------------------------
package bhc_pkg;

  // Parameter defaults.
  localparam int TABLE_DEPTH_DEF = 64;
  localparam int BARCODE_LEN_DEF = 9;
  localparam int BASE_BITS_DEF   = 4;

  // Fixed field widths.
  localparam int BARCODE_W  = 36;
  localparam int ENTRY_W    = 6;
  localparam int CUTOFF_W   = 4;
  localparam int USED_W     = 7;
  localparam int VERDICT_W  = 2;
  localparam int DIST_OUT_W = 4;
  // Distances reach at most 9 bases, and the no-match value reaches 16.
  localparam int DIST_W     = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;

  // Request codes.
  localparam logic REQ_LOAD     = 1'b0;
  localparam logic REQ_CLASSIFY = 1'b1;

  // Verdict codes.
  localparam logic [VERDICT_W-1:0] VERDICT_MATCH = 2'd0;
  localparam logic [VERDICT_W-1:0] VERDICT_AMBIG = 2'd1;
  localparam logic [VERDICT_W-1:0] VERDICT_NONE  = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_MISMATCH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IGNORE_LAST  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ENTRIES_USED = 2'd2;

  // Candidate count saturates at two: only zero, one or several matter.
  localparam logic [1:0] CNT_NONE = 2'd0;
  localparam logic [1:0] CNT_ONE  = 2'd1;
  localparam logic [1:0] CNT_MANY = 2'd2;

  // One word in flight along the chain, with its running search result.
  typedef struct packed {
    logic                 valid;
    logic                 req_type;
    logic [ENTRY_W-1:0]   entry_index;
    logic [BARCODE_W-1:0] barcode;
    logic [DIST_W-1:0]    best;
    logic [1:0]           cnt;
  } token_t;

endpackage : bhc_pkg
`default_nettype wire

// File: sv/bhc_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Barcode classifier cell
// Holds one reference entry, captures loads addressed to it and folds its
// mismatch count into the running result of each passing classify word.
// ----------------------------------------------------------------------------
module bhc_cell #(
  parameter int CELL_INDEX  = 0,
  parameter int IDX_W       = 6,
  parameter int BARCODE_LEN = 9,
  parameter int BASE_BITS   = 4
) (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire                            adv,
  input  wire                            ignore_last,
  input  wire  [bhc_pkg::CUTOFF_W-1:0]   max_mismatch,
  input  wire  [bhc_pkg::USED_W-1:0]     entries_used,
  input  bhc_pkg::token_t                tok_i,
  input  wire  [IDX_W-1:0]               idx_i,
  output bhc_pkg::token_t                tok_o,
  output logic [IDX_W-1:0]               idx_o
);
  import bhc_pkg::*;

  localparam int CODE_W = BARCODE_LEN * BASE_BITS;
  localparam int WORD_W = (CODE_W > BARCODE_W) ? CODE_W : BARCODE_W;
  localparam int CMP_W  = (IDX_W + 1 > USED_W) ? IDX_W + 1 : USED_W;

  logic [BARCODE_W-1:0] ref_r;
  token_t               tok_r;
  token_t               tok_nxt;
  logic [IDX_W-1:0]     idx_r;
  logic [IDX_W-1:0]     idx_nxt;
  logic [WORD_W-1:0]    ref_word;
  logic [WORD_W-1:0]    read_word;
  logic [DIST_W-1:0]    mm_count;
  logic                 active;
  logic                 hit_load;

  assign ref_word  = WORD_W'(ref_r);
  assign read_word = WORD_W'(tok_i.barcode);
  assign active    = CMP_W'(CELL_INDEX) < CMP_W'(entries_used);
  assign hit_load  = tok_i.valid && (tok_i.req_type == REQ_LOAD) &&
                     (CMP_W'(CELL_INDEX) == CMP_W'(tok_i.entry_index));

  // Bases lying beyond the stored word compare as zero on both sides.
  always_comb begin
    mm_count = '0;
    for (int b = 0; b < BARCODE_LEN; b++) begin
      if (!(ignore_last && (b == BARCODE_LEN - 1))) begin
        if (ref_word[b*BASE_BITS +: BASE_BITS] != read_word[b*BASE_BITS +: BASE_BITS]) begin
          mm_count = mm_count + DIST_W'(1);
        end
      end
    end
  end

  always_comb begin
    tok_nxt = tok_i;
    idx_nxt = idx_i;
    if (tok_i.valid && (tok_i.req_type == REQ_CLASSIFY) && active &&
        (mm_count <= DIST_W'(max_mismatch))) begin
      if (mm_count < tok_i.best) begin
        tok_nxt.best = mm_count;
        tok_nxt.cnt  = CNT_ONE;
        idx_nxt      = IDX_W'(CELL_INDEX);
      end else if (mm_count == tok_i.best) begin
        tok_nxt.cnt = (tok_i.cnt == CNT_NONE) ? CNT_ONE : CNT_MANY;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.valid <= 1'b0;
    end else if (adv) begin
      tok_r <= tok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      idx_r <= idx_nxt;
      if (hit_load) begin
        ref_r <= tok_i.barcode;
      end
    end
  end

  assign tok_o = tok_r;
  assign idx_o = idx_r;

endmodule : bhc_cell
`default_nettype wire

// File: sv/barcode_hamming_classifier_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Barcode Hamming classifier
// Classifies read barcodes against a table of references by base mismatches.
// ----------------------------------------------------------------------------
// Usage: every input word is either a load (req_type 0), which writes the
// barcode into reference slot entry_index, or a classify (req_type 1), which
// returns one result word with verdict, match_index and best_distance.
// Loads return nothing; slots at or beyond TABLE_DEPTH are ignored.
// The table is a chain of TABLE_DEPTH cells, one reference per cell. Each
// word walks the chain one cell per cycle, so loads and classifies keep
// their order and a classify sees every load that came before it.
// Throughput is one word per cycle while the chain is not held. A classify
// result passes through the TABLE_DEPTH cells and then the output register.
// When the receiver stalls with a result waiting, the whole chain holds and
// in_ready drops; it resumes as soon as the result is taken.
// Reset empties the chain and restores max_mismatch 1, ignore_last 1 and
// entries_used 0. Reference contents are not cleared and must be loaded
// before use. The user must write configuration via the cfg_ port only while
// idle (not enforced); writes past the list are accepted and dropped.
// ----------------------------------------------------------------------------
module barcode_hamming_classifier_unit #(
  parameter int TABLE_DEPTH = bhc_pkg::TABLE_DEPTH_DEF,
  parameter int BARCODE_LEN = bhc_pkg::BARCODE_LEN_DEF,
  parameter int BASE_BITS   = bhc_pkg::BASE_BITS_DEF
) (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                in_valid,
  output logic                               in_ready,
  input  wire                                in_req_type,
  input  wire  [bhc_pkg::ENTRY_W-1:0]        in_entry_index,
  input  wire  [bhc_pkg::BARCODE_W-1:0]      in_barcode,
  output logic                               out_valid,
  input  wire                                out_ready,
  output logic [bhc_pkg::VERDICT_W-1:0]      out_verdict,
  output logic [bhc_pkg::ENTRY_W-1:0]        out_match_index,
  output logic [bhc_pkg::DIST_OUT_W-1:0]     out_best_distance,
  input  wire                                cfg_valid,
  output logic                               cfg_ready,
  input  wire  [bhc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire  [bhc_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import bhc_pkg::*;

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam logic [DIST_W-1:0] DIST_SAT = DIST_W'((1 << DIST_OUT_W) - 1);

  // Configuration registers.
  logic [CUTOFF_W-1:0] max_mismatch_r;
  logic                ignore_last_r;
  logic [USED_W-1:0]   entries_used_r;

  // Chain links: entry 0 is the word being accepted.
  token_t           tok   [TABLE_DEPTH+1];
  logic [IDX_W-1:0] idx   [TABLE_DEPTH+1];
  logic             adv;

  // Output register.
  logic                  out_valid_r;
  logic [VERDICT_W-1:0]  verdict_r;
  logic [ENTRY_W-1:0]    match_index_r;
  logic [DIST_OUT_W-1:0] best_distance_r;
  logic [VERDICT_W-1:0]  verdict_nxt;
  logic [ENTRY_W-1:0]    match_index_nxt;
  logic [DIST_OUT_W-1:0] best_distance_nxt;
  token_t                last_tok;

  // The chain moves whenever the output register is free or being emptied.
  assign adv       = !out_valid_r || out_ready;
  assign in_ready  = adv;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_mismatch_r <= CUTOFF_W'(1);
      ignore_last_r  <= 1'b1;
      entries_used_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_MAX_MISMATCH: max_mismatch_r <= cfg_data[CUTOFF_W-1:0];
        CFG_IGNORE_LAST:  ignore_last_r  <= cfg_data[0];
        CFG_ENTRIES_USED: entries_used_r <= cfg_data[USED_W-1:0];
        default: ;
      endcase
    end
  end

  // A new word starts with no candidate and the no-match distance.
  always_comb begin
    tok[0].valid       = in_valid;
    tok[0].req_type    = in_req_type;
    tok[0].entry_index = in_entry_index;
    tok[0].barcode     = in_barcode;
    tok[0].best        = DIST_W'(max_mismatch_r) + DIST_W'(1);
    tok[0].cnt         = CNT_NONE;
    idx[0]             = '0;
  end

  for (genvar c = 0; c < TABLE_DEPTH; c++) begin : g_cell
    bhc_cell #(
      .CELL_INDEX  (c),
      .IDX_W       (IDX_W),
      .BARCODE_LEN (BARCODE_LEN),
      .BASE_BITS   (BASE_BITS)
    ) u_cell (
      .clk          (clk),
      .rst_n        (rst_n),
      .adv          (adv),
      .ignore_last  (ignore_last_r),
      .max_mismatch (max_mismatch_r),
      .entries_used (entries_used_r),
      .tok_i        (tok[c]),
      .idx_i        (idx[c]),
      .tok_o        (tok[c+1]),
      .idx_o        (idx[c+1])
    );
  end

  assign last_tok = tok[TABLE_DEPTH];

  // Turn the running search result into the reported fields.
  always_comb begin
    match_index_nxt = '0;
    if (last_tok.cnt == CNT_ONE) begin
      verdict_nxt     = VERDICT_MATCH;
      match_index_nxt = ENTRY_W'(idx[TABLE_DEPTH]);
    end else if (last_tok.cnt == CNT_NONE) begin
      verdict_nxt = VERDICT_NONE;
    end else begin
      verdict_nxt = VERDICT_AMBIG;
    end
    if (last_tok.best > DIST_SAT) begin
      best_distance_nxt = DIST_OUT_W'(DIST_SAT);
    end else begin
      best_distance_nxt = last_tok.best[DIST_OUT_W-1:0];
    end
  end

  // Loads leave the chain here without a result.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= last_tok.valid && (last_tok.req_type == REQ_CLASSIFY);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      verdict_r       <= verdict_nxt;
      match_index_r   <= match_index_nxt;
      best_distance_r <= best_distance_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_verdict       = verdict_r;
  assign out_match_index   = match_index_r;
  assign out_best_distance = best_distance_r;

endmodule : barcode_hamming_classifier_unit
`default_nettype wire

// File: verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Barcode Hamming classifier testbench
// Drives load and classify words into the classifier, keeps its own copy of
// the reference table and the three registers, and checks every result word
// against the verdict worked out from that copy.
// ----------------------------------------------------------------------------
module tb_top;
  import bhc_pkg::*;

  // Geometry of the block under test, taken from the package defaults.
  localparam int DEPTH = TABLE_DEPTH_DEF;
  localparam int BASES = BARCODE_LEN_DEF;
  localparam int BBITS = BASE_BITS_DEF;

  // A classify result leaves the chain only after passing all DEPTH cells, so a
  // load can still be walking the chain after the last result.
  localparam int DRAIN_CYCLES = DEPTH + 16;
  // The long receiver hold-off is several chain lengths, so the chain fills.
  localparam int STALL_CYCLES = 300;
  // Percentage of cycles in which either side idles.
  localparam int IDLE_PCT     = 11;

  // Register index past the end of the list; the block must drop the write.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  // One result word as the block presents it.
  typedef struct packed {
    logic [VERDICT_W-1:0]  verdict;
    logic [ENTRY_W-1:0]    index;
    logic [DIST_OUT_W-1:0] distance;
  } call_t;

  localparam call_t NO_CALL = '0;

  // A row of the directed plan is either an input word or a register write.
  // Rows with typed set carry their expected result written out by hand;
  // every other classify row is checked against the predictor.
  typedef enum logic {ROW_WORD, ROW_REG} row_kind_t;

  typedef struct packed {
    row_kind_t             kind;
    logic                  req;
    logic [ENTRY_W-1:0]    entry;
    logic [BARCODE_W-1:0]  code;
    logic [CFG_IDX_W-1:0]  sel;
    logic [CFG_DATA_W-1:0] data;
    logic                  typed;
    call_t                 want;
  } row_t;

  // Entries 2 and 3 differ only in the last base, so they tie whenever the
  // last base is left out. Entry 63 is loaded but stays outside the used set.
  localparam row_t PLAN [25] = '{
    // Right after reset no entry is in use and the cutoff is one.
    '{ROW_WORD, REQ_CLASSIFY, 6'd0,  36'h000000000, '0, '0, 1'b1, '{VERDICT_NONE, 6'd0, 4'd2}},
    '{ROW_WORD, REQ_LOAD,     6'd0,  36'h000000000, '0, '0, 1'b0, NO_CALL},
    '{ROW_WORD, REQ_LOAD,     6'd1,  36'hFFFFFFFFF, '0, '0, 1'b0, NO_CALL},
    '{ROW_WORD, REQ_LOAD,     6'd2,  36'h123456789, '0, '0, 1'b0, NO_CALL},
    '{ROW_WORD, REQ_LOAD,     6'd3,  36'hA23456789, '0, '0, 1'b0, NO_CALL},
    '{ROW_WORD, REQ_LOAD,     6'd63, 36'h555555555, '0, '0, 1'b0, NO_CALL},
    '{ROW_REG,  '0, '0, '0, CFG_ENTRIES_USED, 7'd4, 1'b0, NO_CALL},
    // Exact hits on the two extreme entries, then a tie on the last base.
    '{ROW_WORD, REQ_CLASSIFY, 6'd0,  36'h000000000, '0, '0, 1'b1, '{VERDICT_MATCH, 6'd0, 4'd0}},
    '{ROW_WORD, REQ_CLASSIFY, 6'd63, 36'hFFFFFFFFF, '0, '0, 1'b1, '{VERDICT_MATCH, 6'd1, 4'd0}},
    '{ROW_WORD, REQ_CLASSIFY, 6'd0,  36'h123456789, '0, '0, 1'b1, '{VERDICT_AMBIG, 6'd0, 4'd0}},
    '{ROW_WORD, REQ_CLASSIFY, 6'd0,  36'h000000001, '0, '0, 1'b0, NO_CALL},
    // Counting the last base breaks the tie.
    '{ROW_REG,  '0, '0, '0, CFG_IGNORE_LAST, 7'd0, 1'b0, NO_CALL},
    '{ROW_WORD, REQ_CLASSIFY, 6'd0,  36'h123456789, '0, '0, 1'b1, '{VERDICT_MATCH, 6'd2, 4'd0}},
    '{ROW_WORD, REQ_CLASSIFY, 6'd0,  36'h555555555, '0, '0, 1'b1, '{VERDICT_NONE, 6'd0, 4'd2}},
    // A zero cutoff accepts exact hits only.
    '{ROW_REG,  '0, '0, '0, CFG_MAX_MISMATCH, 7'd0, 1'b0, NO_CALL},
    '{ROW_WORD, REQ_CLASSIFY, 6'd0,  36'h000000001, '0, '0, 1'b1, '{VERDICT_NONE, 6'd0, 4'd1}},
    // A cutoff as wide as the barcode makes every entry a candidate.
    '{ROW_REG,  '0, '0, '0, CFG_MAX_MISMATCH, 7'd9, 1'b0, NO_CALL},
    '{ROW_WORD, REQ_CLASSIFY, 6'd0,  36'h777777777, '0, '0, 1'b0, NO_CALL},
    '{ROW_REG,  '0, '0, '0, CFG_MAX_MISMATCH, 7'd15, 1'b0, NO_CALL},
    '{ROW_WORD, REQ_CLASSIFY, 6'd0,  36'h000000FFF, '0, '0, 1'b0, NO_CALL},
    // With nothing in use the no-match distance of sixteen saturates.
    '{ROW_REG,  '0, '0, '0, CFG_ENTRIES_USED, 7'd0, 1'b0, NO_CALL},
    '{ROW_WORD, REQ_CLASSIFY, 6'd0,  36'hFFFFFFFFF, '0, '0, 1'b1, '{VERDICT_NONE, 6'd0, 4'd15}},
    // A write past the register list must leave the cutoff alone.
    '{ROW_REG,  '0, '0, '0, CFG_SPARE, 7'd0, 1'b0, NO_CALL},
    '{ROW_REG,  '0, '0, '0, CFG_IGNORE_LAST, 7'd1, 1'b0, NO_CALL},
    '{ROW_WORD, REQ_CLASSIFY, 6'd0,  36'h000000000, '0, '0, 1'b1, '{VERDICT_NONE, 6'd0, 4'd15}}
  };

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  logic                  in_req_type;
  logic [ENTRY_W-1:0]    in_entry_index;
  logic [BARCODE_W-1:0]  in_barcode;
  logic                  out_valid;
  logic                  out_ready;
  logic [VERDICT_W-1:0]  out_verdict;
  logic [ENTRY_W-1:0]    out_match_index;
  logic [DIST_OUT_W-1:0] out_best_distance;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // The testbench's own view of the block: reference table and registers,
  // starting from the reset values of the registers.
  logic [BARCODE_W-1:0]  shadow_refs [DEPTH];
  logic [CUTOFF_W-1:0]   cutoff     = 4'd1;
  logic                  skip_last  = 1'b1;
  logic [USED_W-1:0]     used_count = 7'd0;

  // Verdicts of accepted classify words, oldest first.
  call_t expected_verdicts [$];

  int errors    = 0;
  // While calm is set neither side idles.
  bit calm      = 1'b0;
  // Set by the stimulus to ask the result side for one long hold-off.
  bit stall_req = 1'b0;

  barcode_hamming_classifier_unit u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_req_type       (in_req_type),
    .in_entry_index    (in_entry_index),
    .in_barcode        (in_barcode),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_verdict       (out_verdict),
    .out_match_index   (out_match_index),
    .out_best_distance (out_best_distance),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Works out the result of classifying one read barcode against the
  // entries in use, with the current cutoff and last-base setting.
  function automatic call_t classify_read(input logic [BARCODE_W-1:0] read);
    call_t r;
    int    lim;
    int    span;
    int    d;
    int    best;
    int    hits;
    int    best_at;
    lim     = (used_count > DEPTH) ? DEPTH : int'(used_count);
    span    = skip_last ? BASES - 1 : BASES;
    best    = int'(cutoff) + 1;
    hits    = 0;
    best_at = 0;
    for (int e = 0; e < lim; e++) begin
      d = 0;
      for (int b = 0; b < span; b++) begin
        if (shadow_refs[e][b*BBITS +: BBITS] != read[b*BBITS +: BBITS]) d++;
      end
      // Entries beyond the cutoff never count, even when they tie.
      if (d <= int'(cutoff)) begin
        if (d < best) begin
          best    = d;
          best_at = e;
          hits    = 1;
        end else if (d == best) begin
          hits++;
        end
      end
    end
    if (hits == 1) begin
      r.verdict = VERDICT_MATCH;
      r.index   = best_at[ENTRY_W-1:0];
    end else begin
      r.verdict = (hits > 1) ? VERDICT_AMBIG : VERDICT_NONE;
      r.index   = '0;
    end
    // A cutoff of fifteen with no candidate reports sixteen, held at fifteen.
    r.distance = (best > 15) ? 4'd15 : best[DIST_OUT_W-1:0];
    return r;
  endfunction

  function automatic logic [BARCODE_W-1:0] random_barcode();
    logic [63:0] raw;
    raw = {$urandom(), $urandom()};
    return raw[BARCODE_W-1:0];
  endfunction

  // Changes a number of randomly chosen bases to a different value. The same
  // base may be hit twice, so the distance can come out below the count.
  function automatic logic [BARCODE_W-1:0] perturb_bases(input logic [BARCODE_W-1:0] code,
                                                         input int flips);
    logic [BARCODE_W-1:0] v;
    int                   pos;
    int                   bits;
    v = code;
    repeat (flips) begin
      pos  = $urandom_range(0, BASES - 1);
      bits = $urandom_range(1, (1 << BBITS) - 1);
      v[pos*BBITS +: BBITS] = v[pos*BBITS +: BBITS] ^ bits[BBITS-1:0];
    end
    return v;
  endfunction

  task automatic compare_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endtask

  // Offers one word, with random idle cycles ahead of it, and returns at the
  // edge where it is accepted. A load updates the table copy there; a
  // classify leaves its expected verdict in the queue.
  task automatic push_word(input logic req, input logic [ENTRY_W-1:0] entry,
                           input logic [BARCODE_W-1:0] code, input logic typed,
                           input call_t want);
    call_t exp_call;
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_req_type    <= req;
    in_entry_index <= entry;
    in_barcode     <= code;
    do @(posedge clk); while (!in_ready);
    if (req == REQ_LOAD) begin
      shadow_refs[entry] = code;
    end else begin
      exp_call          = typed ? want : classify_read(code);
      expected_verdicts = {expected_verdicts, exp_call};
    end
  endtask

  // Stops offering words, waits for every expected result, then gives a load
  // still in the chain time to reach its cell.
  task automatic settle();
    in_valid <= 1'b0;
    while (expected_verdicts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] sel, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= sel;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (sel)
      CFG_MAX_MISMATCH: cutoff     = data[CUTOFF_W-1:0];
      CFG_IGNORE_LAST:  skip_last  = data[0];
      CFG_ENTRIES_USED: used_count = data[USED_W-1:0];
      default: ;
    endcase
  endtask

  // One stretch of random traffic under one register setting. Most words
  // classify a read a few bases away from an entry in use, so that matches,
  // ties and near misses around the cutoff all show up; the rest are loads,
  // which often copy a neighbor to create ties, and plain noise.
  task automatic run_phase(input int cut, input int skip, input int used, input int words,
                           input bit hold, input bit quiet);
    int                   lim;
    int                   pick;
    int                   e;
    logic [BARCODE_W-1:0] code;
    settle();
    write_reg(CFG_MAX_MISMATCH, cut[CFG_DATA_W-1:0]);
    write_reg(CFG_IGNORE_LAST, skip[CFG_DATA_W-1:0]);
    write_reg(CFG_ENTRIES_USED, used[CFG_DATA_W-1:0]);
    lim  = (used > DEPTH) ? DEPTH : used;
    calm = quiet;
    if (hold) stall_req = 1'b1;
    repeat (words) begin
      pick = $urandom_range(0, 99);
      e    = $urandom_range(0, DEPTH - 1);
      if (pick < 15) begin
        if (pick < 8) begin
          code = perturb_bases(shadow_refs[$urandom_range(0, DEPTH - 1)], $urandom_range(1, 2));
        end else begin
          code = random_barcode();
        end
        push_word(REQ_LOAD, e[ENTRY_W-1:0], code, 1'b0, NO_CALL);
      end else begin
        if (pick < 85) begin
          code = perturb_bases(shadow_refs[$urandom_range(0, lim - 1)],
                               $urandom_range(0, cut + 2));
        end else if (pick < 90) begin
          code = pick[0] ? '1 : '0;
        end else begin
          code = random_barcode();
        end
        // The entry index is unused by a classify, so it carries noise.
        push_word(REQ_CLASSIFY, e[ENTRY_W-1:0], code, 1'b0, NO_CALL);
      end
    end
    calm = 1'b0;
  endtask

  // Result side: checks each accepted result word against the oldest
  // expectation and drives out_ready, with random idling and, on request,
  // one long hold-off that it counts down itself.
  initial begin : result_sink
    int hold_left;
    call_t want;
    hold_left = 0;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        if (expected_verdicts.size() == 0) begin
          $display("%0t ns: result word with none expected: expected nothing, actual %0d/%0d/%0d",
                   $time, out_verdict, out_match_index, out_best_distance);
          errors++;
        end else begin
          want = expected_verdicts.pop_front();
          compare_field("verdict", 8'(want.verdict), 8'(out_verdict));
          compare_field("match_index", 8'(want.index), 8'(out_match_index));
          compare_field("best_distance", 8'(want.distance), 8'(out_best_distance));
        end
      end
      if (stall_req) begin
        stall_req = 1'b0;
        hold_left = STALL_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  initial begin : stimulus
    logic [BARCODE_W-1:0] code;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_req_type    = REQ_LOAD;
    in_entry_index = '0;
    in_barcode     = '0;
    cfg_valid      = 1'b0;
    cfg_index      = CFG_MAX_MISMATCH;
    cfg_data       = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. Register rows wait for the block to drain first.
    foreach (PLAN[i]) begin
      if (PLAN[i].kind == ROW_REG) begin
        settle();
        write_reg(PLAN[i].sel, PLAN[i].data);
      end else begin
        push_word(PLAN[i].req, PLAN[i].entry, PLAN[i].code, PLAN[i].typed, PLAN[i].want);
      end
    end

    // Fill the whole table before any random phase uses it. About a third of
    // the entries are near copies of earlier ones, so reads can land on ties.
    for (int e = 0; e < DEPTH; e++) begin
      if (e > 0 && $urandom_range(0, 2) == 0) begin
        code = perturb_bases(shadow_refs[$urandom_range(0, e - 1)], $urandom_range(1, 2));
      end else begin
        code = random_barcode();
      end
      push_word(REQ_LOAD, e[ENTRY_W-1:0], code, 1'b0, NO_CALL);
    end

    // Fixed settings cover the extremes: exact hits only with the last base
    // counted under a long receiver hold-off, a wide cutoff with an
    // oversized entry count and no idling, the saturating cutoff, and a
    // single entry. Random settings follow.
    run_phase(2, 1, DEPTH, 50, 1'b0, 1'b0);
    run_phase(0, 0, DEPTH, 100, 1'b1, 1'b0);
    run_phase(9, 1, 127, 50, 1'b0, 1'b1);
    run_phase(15, 0, DEPTH, 40, 1'b0, 1'b0);
    run_phase(3, 0, 1, 40, 1'b0, 1'b0);
    repeat (3) begin
      run_phase($urandom_range(0, 9), $urandom_range(0, 1), $urandom_range(1, DEPTH),
                40, 1'b0, 1'b0);
    end

    settle();
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // A correct run takes well under a tenth of this.
  initial begin : watchdog
    #2_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule : tb_top

// File: sim.f
sv/bhc_pkg.sv
sv/bhc_cell.sv
sv/barcode_hamming_classifier_unit.sv
verif/tb_top.sv
